/* hw/rtl/lcs_pkg.sv */
// Package for the line centroid steering block.
// Holds shared constants, register indexes, direction codes and the queue entry type.
package lcs_pkg;

  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxHeightDef = 1024;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 24;
  localparam int unsigned CountW       = 21;
  localparam int unsigned SumW         = 30;

  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLowerHsv    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegUpperHsv    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegTurnTol     = 3'd4;

  localparam logic [1:0] DirLeft     = 2'd0;
  localparam logic [1:0] DirStraight = 2'd1;
  localparam logic [1:0] DirRight    = 2'd2;
  localparam logic [1:0] DirSearch   = 2'd3;

  // One classified pixel as passed from the front to the back part.
  typedef struct packed {
    logic       hit;
    logic       first;
    logic       last;
  } lcs_cls_t;

endpackage

/* hw/rtl/lcs_front.sv */
// Front part: converts a BGR pixel to HSV and tests it against the bounds.
// Depends on lcs_pkg for the queue entry type.
module lcs_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         blue_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         red_i,
  input  logic               first_i,
  input  logic               last_i,
  input  logic [23:0]        lower_hsv_i,
  input  logic [23:0]        upper_hsv_i,
  output logic               cls_valid_o,
  input  logic               cls_ready_i,
  output lcs_pkg::lcs_cls_t  cls_o
);

  // Stage 1 registers: products of the reciprocal multiply.
  logic        s1_valid_q;
  logic        s1_first_q, s1_last_q;
  logic [7:0]  s1_v_q;
  logic [27:0] s1_sprod_q;
  logic signed [28:0] s1_hprod_q;
  logic        s2_valid_q;
  lcs_pkg::lcs_cls_t s2_cls_q;
  logic        s2_ready, s1_ready;

  logic [7:0] vmax, vmin, diff;
  logic signed [11:0] hnum;
  logic [19:0] sdiv;
  logic [17:0] hdiv;

  // Constant reciprocal tables: rounded 255*4096/v and 122880/d, zero at index zero.
  logic [19:0] sat_tab [256];
  logic [17:0] hue_tab [256];

  assign sat_tab[0] = '0;
  assign hue_tab[0] = '0;

  for (genvar gi = 1; gi < 256; gi++) begin : g_recip
    localparam int unsigned SatR = (2 * 255 * 4096 + gi) / (2 * gi);
    localparam int unsigned HueR = (2 * 122880 + gi) / (2 * gi);
    assign sat_tab[gi] = 20'(SatR);
    assign hue_tab[gi] = 18'(HueR);
  end

  // Max, min and hue numerator.
  always_comb begin
    vmax = blue_i;
    if (green_i > vmax) vmax = green_i;
    if (red_i > vmax) vmax = red_i;
    vmin = blue_i;
    if (green_i < vmin) vmin = green_i;
    if (red_i < vmin) vmin = red_i;
    diff = vmax - vmin;
    sdiv = sat_tab[vmax];
    hdiv = hue_tab[diff];
    if (vmax == red_i) begin
      hnum = $signed({4'd0, green_i}) - $signed({4'd0, blue_i});
    end else if (vmax == green_i) begin
      hnum = $signed({4'd0, blue_i}) - $signed({4'd0, red_i}) + $signed({3'd0, diff, 1'b0});
    end else begin
      hnum = $signed({4'd0, red_i}) - $signed({4'd0, green_i}) + $signed({2'd0, diff, 2'd0});
    end
  end

  assign s2_ready   = !s2_valid_q || cls_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  // Multiply stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_first_q <= first_i;
      s1_last_q  <= last_i;
      s1_v_q     <= vmax;
      s1_sprod_q <= {20'd0, diff} * sdiv;
      s1_hprod_q <= 29'(hnum * $signed({1'b0, hdiv}));
    end
  end

  // Rounding and bound test.
  logic [7:0] s_val, h_val;
  logic [16:0] s_round;
  logic signed [28:0] h_round;
  logic signed [16:0] h_fl;
  logic hit;

  always_comb begin
    s_round = 17'((s1_sprod_q + 28'd2048) >> 12);
    s_val   = s_round[7:0];
    h_round = s1_hprod_q + 29'sd2048;
    h_fl    = 17'(h_round >>> 12);
    if (h_fl < 0) h_fl = h_fl + 17'sd180;
    h_val = h_fl[7:0];
    hit = (h_val >= lower_hsv_i[23:16]) && (h_val <= upper_hsv_i[23:16]) &&
          (s_val >= lower_hsv_i[15:8])  && (s_val <= upper_hsv_i[15:8]) &&
          (s1_v_q >= lower_hsv_i[7:0])  && (s1_v_q <= upper_hsv_i[7:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_cls_q.hit   <= hit;
      s2_cls_q.first <= s1_first_q;
      s2_cls_q.last  <= s1_last_q;
    end
  end

  assign cls_valid_o = s2_valid_q;
  assign cls_o       = s2_cls_q;

endmodule

/* hw/rtl/lcs_queue.sv */
// Short queue between the front and back parts.
// Depends on lcs_pkg for the entry type.
module lcs_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_ready_o,
  input  lcs_pkg::lcs_cls_t wr_data_i,
  output logic              rd_valid_o,
  input  logic              rd_ready_i,
  output lcs_pkg::lcs_cls_t rd_data_o
);

  lcs_pkg::lcs_cls_t mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic wr_en, rd_en;

  assign wr_ready_o = (cnt_q != 3'd4);
  assign rd_valid_o = (cnt_q != 3'd0);
  assign wr_en = wr_valid_i && wr_ready_o;
  assign rd_en = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) wp_q <= wp_q + 2'd1;
      if (rd_en) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + {2'd0, wr_en} - {2'd0, rd_en};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wp_q] <= wr_data_i;
  end

endmodule

/* hw/rtl/lcs_back.sv */
// Back part: tracks position, accumulates totals and decides the direction.
// Depends on lcs_pkg for widths, direction codes and the entry type.
module lcs_back #(
  parameter int unsigned MaxWidth  = lcs_pkg::MaxWidthDef,
  parameter int unsigned MaxHeight = lcs_pkg::MaxHeightDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cls_valid_i,
  output logic              cls_ready_o,
  input  lcs_pkg::lcs_cls_t cls_i,
  input  logic [10:0]       frame_width_i,
  input  logic [10:0]       frame_height_i,
  input  logic [9:0]        turn_tol_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output logic [1:0]        direction_o,
  output logic [lcs_pkg::CountW-1:0] count_o,
  output logic [lcs_pkg::SumW-1:0]   sum_o
);

  localparam int unsigned XW = $clog2(MaxWidth + 1);
  localparam int unsigned YW = $clog2(MaxHeight + 1);
  localparam int unsigned CW = lcs_pkg::CountW;
  localparam int unsigned SW = lcs_pkg::SumW;
  // Threshold width: wide enough for half the width and the full tolerance.
  localparam int unsigned TW = ((XW > 10) ? XW : 10) + 2;
  // floor(n/10) = (n*RecipTen) >> 19 and floor(n/5) = (n*RecipFive) >> 18 for n < 2^18.
  localparam int unsigned RecipTen  = 52429;
  localparam int unsigned RecipFive = 52429;

  // Effective dimensions and window limits (registers the user keeps stable while busy).
  logic [XW-1:0] w_eff;
  logic [YW-1:0] h_eff;
  logic [XW+3:0] xlo, xhi;
  logic [YW+2:0] ylo;

  always_comb begin
    if (frame_width_i == 11'd0) w_eff = XW'(1);
    else if ({21'd0, frame_width_i} > 32'(MaxWidth)) w_eff = XW'(MaxWidth);
    else w_eff = XW'(frame_width_i);
    if (frame_height_i == 11'd0) h_eff = YW'(1);
    else if ({21'd0, frame_height_i} > 32'(MaxHeight)) h_eff = YW'(MaxHeight);
    else h_eff = YW'(frame_height_i);
    xlo = (XW+4)'(((XW+21)'(w_eff) * (XW+21)'(3 * RecipTen)) >> 19);
    xhi = (XW+4)'(((XW+21)'(w_eff) * (XW+21)'(7 * RecipTen)) >> 19);
    ylo = (YW+3)'(((YW+21)'(h_eff) * (YW+21)'(4 * RecipFive)) >> 18);
  end

  // Frame state.
  logic [XW-1:0] col_q, col_d;
  logic [YW-1:0] row_q, row_d;
  logic          beyond_q, beyond_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [SW-1:0] sum_q, sum_d;
  logic          dec_q;
  logic [CW-1:0] dcnt_q;
  logic [SW-1:0] dsum_q;
  logic          rv_q;
  logic [1:0]    dir_q;
  logic [CW-1:0] ocnt_q;
  logic [SW-1:0] osum_q;

  // Busy while a result is being decided or waits.
  assign cls_ready_o = !dec_q && !rv_q;

  logic          take;
  logic [XW-1:0] x0;
  logic [YW-1:0] y0;
  logic [CW-1:0] c0;
  logic [SW-1:0] s0;
  logic          b0, count_it;

  always_comb begin
    take = cls_valid_i && cls_ready_o;
    x0 = cls_i.first ? '0 : col_q;
    y0 = cls_i.first ? '0 : row_q;
    c0 = cls_i.first ? '0 : cnt_q;
    s0 = cls_i.first ? '0 : sum_q;
    b0 = cls_i.first ? 1'b0 : beyond_q;
    count_it = !b0 && cls_i.hit && ({3'd0, y0} >= ylo) &&
               ({4'd0, x0} >= xlo) && ({4'd0, x0} < xhi);
  end

  // Next frame state: a closing pixel clears all; others update totals and position.
  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    beyond_d = beyond_q;
    cnt_d    = cnt_q;
    sum_d    = sum_q;
    if (take) begin
      if (cls_i.last) begin
        col_d    = '0;
        row_d    = '0;
        beyond_d = 1'b0;
        cnt_d    = '0;
        sum_d    = '0;
      end else begin
        cnt_d    = count_it ? c0 + CW'(1) : c0;
        sum_d    = count_it ? s0 + SW'(x0) : s0;
        beyond_d = b0;
        col_d    = x0;
        row_d    = y0;
        if (!b0) begin
          if ({1'b0, x0} + 1'b1 >= {1'b0, w_eff}) begin
            col_d = '0;
            if ({1'b0, y0} + 1'b1 >= {1'b0, h_eff}) beyond_d = 1'b1;
            else row_d = y0 + YW'(1);
          end else begin
            col_d = x0 + XW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      beyond_q <= 1'b0;
      cnt_q <= '0;
      sum_q <= '0;
      dec_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      beyond_q <= beyond_d;
      cnt_q <= cnt_d;
      sum_q <= sum_d;
      dec_q <= take && cls_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && cls_i.last) begin
      dcnt_q <= count_it ? c0 + CW'(1) : c0;
      dsum_q <= count_it ? s0 + SW'(x0) : s0;
    end
  end

  // Direction by cross-multiplication.
  logic signed [TW-1:0] lo_th, hi_th;
  logic signed [TW+CW:0] lo_p, hi_p;
  logic signed [TW+CW:0] ssum;
  logic [1:0] dir;

  always_comb begin
    lo_th = $signed(TW'(w_eff >> 1)) - $signed(TW'(turn_tol_i));
    hi_th = $signed(TW'(w_eff >> 1)) + $signed(TW'(turn_tol_i));
    lo_p = lo_th * $signed({2'b0, dcnt_q});
    hi_p = hi_th * $signed({2'b0, dcnt_q});
    ssum = $signed((TW+CW+1)'(dsum_q));
    if (dcnt_q == '0) dir = lcs_pkg::DirSearch;
    else if (ssum < lo_p) dir = lcs_pkg::DirLeft;
    else if (ssum > hi_p) dir = lcs_pkg::DirRight;
    else dir = lcs_pkg::DirStraight;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rv_q <= 1'b0;
    else if (dec_q) rv_q <= 1'b1;
    else if (res_ready_i) rv_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (dec_q) begin
      dir_q <= dir;
      ocnt_q <= dcnt_q;
      osum_q <= dsum_q;
    end
  end

  assign res_valid_o = rv_q;
  assign direction_o = dir_q;
  assign count_o = ocnt_q;
  assign sum_o = osum_q;

endmodule

/* hw/rtl/line_centroid_steering.sv */
// Top level of the line centroid steering block.
// Instantiates lcs_front, lcs_queue and lcs_back; uses lcs_pkg.
//
// Pixels enter on the s_axis channel, one transaction per pixel, with
// first_pixel in tuser and last_pixel in tlast. A front pipeline of two
// stages turns each pixel into HSV and tests it against the bounds; a
// four-entry queue hands the result to the back part, which tracks the
// position and sums count and column. Pixels flow at one per cycle unless
// a pending result or a receiver stall holds them. The pixel that carries
// last_pixel makes one result transaction on m_axis, registered through
// dec_q and then rv_q after the back part takes it; the back part takes
// no pixel until that result has been taken. Other pixels give no result.
// When the receiver stalls, the result is held, the queue fills, and
// s_axis_tready falls. Reset clears all control state, frame totals and
// restores register defaults. The user writes registers through cfg_we_i
// only while the block is idle; the block itself does not enforce this.
module line_centroid_steering #(
  parameter int unsigned MaxWidth  = lcs_pkg::MaxWidthDef,
  parameter int unsigned MaxHeight = lcs_pkg::MaxHeightDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [lcs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lcs_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // blue [7:0], green [15:8], red [23:16]
  input  logic        s_axis_tuser,   // first_pixel
  input  logic        s_axis_tlast,   // last_pixel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // direction [1:0], count [22:2], sum [52:23], zeros
);

  logic [10:0] width_q, height_q;
  logic [23:0] lower_q, upper_q;
  logic [9:0]  tol_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 11'd640;
      height_q <= 11'd480;
      lower_q <= 24'd25650;
      upper_q <= 24'd2279624;
      tol_q <= 10'd15;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lcs_pkg::RegFrameWidth:  width_q <= cfg_data_i[10:0];
        lcs_pkg::RegFrameHeight: height_q <= cfg_data_i[10:0];
        lcs_pkg::RegLowerHsv:    lower_q <= cfg_data_i;
        lcs_pkg::RegUpperHsv:    upper_q <= cfg_data_i;
        lcs_pkg::RegTurnTol:     tol_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  logic fv, fr, qv, qr;
  lcs_pkg::lcs_cls_t fd, qd;
  logic [1:0] dir;
  logic [lcs_pkg::CountW-1:0] cnt;
  logic [lcs_pkg::SumW-1:0] sum;

  lcs_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .blue_i(s_axis_tdata[7:0]), .green_i(s_axis_tdata[15:8]), .red_i(s_axis_tdata[23:16]),
    .first_i(s_axis_tuser), .last_i(s_axis_tlast),
    .lower_hsv_i(lower_q), .upper_hsv_i(upper_q),
    .cls_valid_o(fv), .cls_ready_i(fr), .cls_o(fd)
  );

  lcs_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(fv), .wr_ready_o(fr), .wr_data_i(fd),
    .rd_valid_o(qv), .rd_ready_i(qr), .rd_data_o(qd)
  );

  lcs_back #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_back (
    .clk_i, .rst_ni,
    .cls_valid_i(qv), .cls_ready_o(qr), .cls_i(qd),
    .frame_width_i(width_q), .frame_height_i(height_q), .turn_tol_i(tol_q),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .direction_o(dir), .count_o(cnt), .sum_o(sum)
  );

  assign m_axis_tdata = {3'd0, sum, cnt, dir};

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the line centroid steering block.
// Depends on lcs_pkg and line_centroid_steering; predicts each frame result in place.
`timescale 1ns / 100ps

module testbench;

  // One pixel transaction, with an optional hand-written frame result.
  typedef struct {
    logic [7:0]  b, g, r;
    logic        first, last;
    logic        typed;
    logic [1:0]  dir;
    logic [20:0] cnt;
    logic [29:0] sum;
  } pixel_t;

  typedef struct {
    logic [1:0]  dir;
    logic [20:0] cnt;
    logic [29:0] sum;
  } steer_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [lcs_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [lcs_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata = '0;  // blue [7:0], green [15:8], red [23:16]
  logic                s_axis_tuser = 1'b0; // first_pixel
  logic                s_axis_tlast = 1'b0; // last_pixel
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [55:0]         m_axis_tdata;       // direction [1:0], count [22:2], sum [52:23]

  // Shadow of the block's registers and frame state.
  logic [10:0] m_width, m_height;
  logic [23:0] m_lower, m_upper;
  logic [9:0]  m_tol;
  int unsigned col_pos, row_pos, line_count, col_sum;
  bit          past_frame;

  pixel_t offered_q[$];
  steer_t steer_q[$];
  int     errors = 0;
  int     n_items = 0;
  int     n_results = 0;
  bit     stim_done = 1'b0;

  line_centroid_steering dut (.*);

  // Clock: 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit.
  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int unsigned clamp_dim(logic [10:0] v);
    if (v == 0) return 1;
    return (v > 1024) ? 1024 : v;
  endfunction

  // Fixed-point BGR to HSV, then the inclusive bound test.
  function automatic bit is_line_color(int b, int g, int r);
    int v, mn, diff, sdiv, hdiv, s, h;
    v = b; mn = b;
    if (g > v) v = g;
    if (r > v) v = r;
    if (g < mn) mn = g;
    if (r < mn) mn = r;
    diff = v - mn;
    sdiv = (v != 0) ? (2 * 255 * 4096 + v) / (2 * v) : 0;
    hdiv = (diff != 0) ? (245760 + diff) / (2 * diff) : 0;
    s = (diff * sdiv + 2048) >> 12;
    if (v == r) h = g - b;
    else if (v == g) h = b - r + 2 * diff;
    else h = r - g + 4 * diff;
    h = (h * hdiv + 2048) >>> 12;
    if (h < 0) h += 180;
    h &= 255; s &= 255;
    return h >= m_lower[23:16] && h <= m_upper[23:16] &&
           s >= m_lower[15:8] && s <= m_upper[15:8] &&
           v >= m_lower[7:0] && v <= m_upper[7:0];
  endfunction

  function automatic void clear_frame();
    col_pos = 0; row_pos = 0; line_count = 0; col_sum = 0; past_frame = 0;
  endfunction

  // Advance the frame state by one pixel; true when a result is due.
  function automatic bit track_pixel(pixel_t p, output steer_t res);
    int unsigned w, hg;
    longint half, tol, cnt, sum;
    w = clamp_dim(m_width);
    hg = clamp_dim(m_height);
    if (p.first) clear_frame();
    if (!past_frame) begin
      if (is_line_color(p.b, p.g, p.r) && row_pos >= (4 * hg) / 5 &&
          col_pos >= (3 * w) / 10 && col_pos < (7 * w) / 10) begin
        line_count = (line_count + 1) & 21'h1FFFFF;
        col_sum = (col_sum + col_pos) & 30'h3FFFFFFF;
      end
      if (col_pos + 1 >= w) begin
        col_pos = 0;
        if (row_pos + 1 >= hg) past_frame = 1;
        else row_pos++;
      end else begin
        col_pos++;
      end
    end
    if (!p.last) return 0;
    if (line_count == 0) begin
      res.dir = lcs_pkg::DirSearch;
    end else begin
      cnt = line_count; sum = col_sum; half = w / 2; tol = m_tol;
      if (sum < (half - tol) * cnt) res.dir = lcs_pkg::DirLeft;
      else if (sum > (half + tol) * cnt) res.dir = lcs_pkg::DirRight;
      else res.dir = lcs_pkg::DirStraight;
    end
    res.cnt = 21'(line_count);
    res.sum = 30'(col_sum);
    clear_frame();
    return 1;
  endfunction

  // Prediction on accepted pixels, checking on accepted results.
  always @(posedge clk_i) begin
    pixel_t p;
    steer_t want, got;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      p = offered_q.pop_front();
      if (track_pixel(p, want)) begin
        if (p.typed) begin
          want.dir = p.dir; want.cnt = p.cnt; want.sum = p.sum;
        end
        steer_q.push_back(want);
      end
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.dir = m_axis_tdata[1:0];
      got.cnt = m_axis_tdata[22:2];
      got.sum = m_axis_tdata[52:23];
      if (steer_q.size() == 0) begin
        $display("%t unexpected result dir=%0d cnt=%0d sum=%0d",
                 $realtime, got.dir, got.cnt, got.sum);
        errors++;
      end else begin
        want = steer_q.pop_front();
        if (got.dir !== want.dir) begin
          $display("%t direction expected %0d actual %0d", $realtime, want.dir, got.dir);
          errors++;
        end
        if (got.cnt !== want.cnt) begin
          $display("%t count expected %0d actual %0d", $realtime, want.cnt, got.cnt);
          errors++;
        end
        if (got.sum !== want.sum) begin
          $display("%t column sum expected %0d actual %0d", $realtime, want.sum, got.sum);
          errors++;
        end
      end
    end
  end

  // Result receiver: random stalls, quiet stretches and one long hold-off.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (n_results == 12) gap = 400;
      else if ((n_results / 16) % 3 == 1) gap = 0;
      else gap = $urandom_range(0, 18);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      n_results++;
    end
  end

  task automatic send_pixel(pixel_t p);
    int gap;
    gap = ((n_items / 40) % 4 == 2) ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    offered_q.push_back(p);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {p.r, p.g, p.b};
    s_axis_tuser <= p.first;
    s_axis_tlast <= p.last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n_items++;
  endtask

  // Let the block drain, then write all five registers.
  task automatic configure(logic [10:0] w, logic [10:0] h, logic [23:0] lo,
                           logic [23:0] hi, logic [9:0] tol);
    s_axis_tvalid <= 1'b0;
    repeat (12) @(posedge clk_i);
    while (steer_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= lcs_pkg::RegFrameWidth;  cfg_data_i <= 24'(w);   @(posedge clk_i);
    cfg_idx_i <= lcs_pkg::RegFrameHeight; cfg_data_i <= 24'(h);   @(posedge clk_i);
    cfg_idx_i <= lcs_pkg::RegLowerHsv;    cfg_data_i <= lo;       @(posedge clk_i);
    cfg_idx_i <= lcs_pkg::RegUpperHsv;    cfg_data_i <= hi;       @(posedge clk_i);
    cfg_idx_i <= lcs_pkg::RegTurnTol;     cfg_data_i <= 24'(tol); @(posedge clk_i);
    cfg_we_i <= 1'b0;
    m_width = w; m_height = h; m_lower = lo; m_upper = hi; m_tol = tol;
  endtask

  function automatic pixel_t mk(int b, int g, int r, bit f, bit l);
    pixel_t p;
    p.b = 8'(b); p.g = 8'(g); p.r = 8'(r); p.first = f; p.last = l; p.typed = 0;
    p.dir = '0; p.cnt = '0; p.sum = '0;
    return p;
  endfunction

  function automatic pixel_t mk_exp(int b, int g, int r, bit f, bit l,
                                    logic [1:0] d, int c, int s);
    pixel_t p;
    p = mk(b, g, r, f, l);
    p.typed = 1; p.dir = d; p.cnt = 21'(c); p.sum = 30'(s);
    return p;
  endfunction

  // One frame of random pixels, mostly well formed, sometimes broken.
  task automatic random_frame();
    int unsigned n, kind, i;
    pixel_t p;
    n = clamp_dim(m_width) * clamp_dim(m_height);
    kind = $urandom_range(0, 9);
    if (kind == 7) n = $urandom_range(1, n);
    else if (kind == 8) n = n + $urandom_range(1, 6);
    if (n > 64) n = $urandom_range(1, 64);
    for (i = 0; i < n; i++) begin
      p = mk($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
             i == 0 && kind != 9, i == n - 1);
      if (kind == 6 && $urandom_range(0, 30) == 0) p.first = 1;
      if (kind == 6 && $urandom_range(0, 30) == 0) p.last = 1;
      send_pixel(p);
    end
  endtask

  initial begin
    pixel_t directed[$];
    int k, frames;
    logic [10:0] w, h;
    logic [23:0] lo, hi;
    m_width = 640; m_height = 480; m_lower = 25650; m_upper = 2279624; m_tol = 15;
    clear_frame();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: black and white one-pixel frames find no line.
    send_pixel(mk_exp(0, 0, 0, 1, 1, lcs_pkg::DirSearch, 0, 0));
    send_pixel(mk_exp(255, 255, 255, 1, 1, lcs_pkg::DirSearch, 0, 0));
    send_pixel(mk(0, 0, 255, 1, 1));

    // Five by one frame, every color accepted, window columns one and two.
    configure(5, 1, 24'h000000, 24'hFFFFFF, 0);
    directed = '{mk(0, 0, 255, 1, 0), mk(0, 255, 0, 0, 0), mk(255, 0, 0, 0, 0),
                 mk(255, 255, 0, 0, 0), mk_exp(0, 255, 255, 0, 1, lcs_pkg::DirLeft, 2, 3),
                 // Frame runs past its end, then closes on last_pixel.
                 mk(10, 20, 30, 1, 0), mk(200, 100, 50, 0, 0), mk(1, 2, 3, 0, 0),
                 mk(9, 9, 9, 0, 0), mk(0, 0, 0, 0, 0), mk(255, 255, 255, 0, 0),
                 mk(255, 0, 255, 0, 1),
                 // Frame with no first_pixel after a clean close.
                 mk(0, 0, 255, 0, 0), mk(0, 0, 255, 0, 0), mk(0, 0, 255, 0, 1)};
    foreach (directed[i]) send_pixel(directed[i]);

    // Large tolerance makes the left threshold negative; the one-pixel window is empty.
    configure(0, 0, 24'h000000, 24'hFFFFFF, 10'h3FF);
    send_pixel(mk_exp(0, 0, 0, 1, 1, lcs_pkg::DirSearch, 0, 0));
    // Inverted bounds match nothing.
    configure(2047, 2047, 24'hFFFFFF, 24'h000000, 0);
    for (k = 0; k < 4; k++) send_pixel(mk(k * 60, 255 - k, 7, k == 0, k == 3));

    // Random phases with random settings, extremes now and then.
    while (n_items < 750) begin
      case ($urandom_range(0, 5))
        0: begin w = $urandom_range(1000, 1100); h = $urandom_range(0, 1); end
        1: begin w = $urandom_range(0, 3); h = $urandom_range(0, 3); end
        default: begin w = $urandom_range(2, 16); h = $urandom_range(1, 8); end
      endcase
      if ($urandom_range(0, 4) == 0) begin
        lo = $urandom; hi = $urandom;
      end else begin
        lo = {8'($urandom_range(0, 40)), 8'($urandom_range(0, 80)),
              8'($urandom_range(0, 80))};
        hi = {8'($urandom_range(100, 255)), 8'($urandom_range(180, 255)),
              8'($urandom_range(180, 255))};
      end
      configure(w, h, lo, hi,
                ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 3)));
      frames = $urandom_range(3, 8);
      for (k = 0; k < frames && n_items < 750; k++) random_frame();
    end

    s_axis_tvalid <= 1'b0;
    repeat (12) @(posedge clk_i);
    while (steer_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
